// ===== rtl/fdts_pkg.sv =====
// Shared types, constants and helpers for the fuzzy distance-to-speed block.
// Depends on nothing; every other file in rtl/ imports it.
package fdts_pkg;

    localparam int DIST_W  = 16;
    localparam int SPEED_W = 15;
    localparam int GRADE_W = 17;
    localparam int QUO_W   = 17;
    localparam int OFF_W   = 13;
    localparam int RCP_W   = 25;
    localparam int GP_W    = OFF_W + RCP_W;

    localparam logic [GRADE_W-1:0] GRADE_ONE = 17'd65536;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 15'd30720;

    // distance breakpoints in input units (4 fraction bits)
    localparam logic signed [17:0] D250  = 18'sd4000;
    localparam logic signed [17:0] D450  = 18'sd7200;
    localparam logic signed [17:0] D500  = 18'sd8000;
    localparam logic signed [17:0] D750  = 18'sd12000;

    localparam logic [OFF_W-1:0] SPAN_SMALL = 13'd7200;
    localparam logic [OFF_W-1:0] SPAN_MID   = 13'd4000;
    localparam logic [OFF_W-1:0] SPAN_LARGE = 13'd8000;

    // off * 65536 / span is (off * RCP) >> SH, exact for every offset up to the span
    localparam logic [RCP_W-1:0] RCP_SMALL = 25'd19088744;
    localparam logic [RCP_W-1:0] RCP_MID   = 25'd8589935;
    localparam logic [RCP_W-1:0] RCP_LARGE = 25'd8589935;
    localparam int SH_SMALL = 21;
    localparam int SH_MID   = 19;
    localparam int SH_LARGE = 20;

    // per sample step the speed advances by 3 * 65536 / 1000 = 196 rem 608
    localparam logic [10:0] STEP_R = 11'd608;
    localparam logic [10:0] R_MOD  = 11'd1000;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic grade_wr;
        logic sweep_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sweep_last;
        logic pipe_busy;
    } t_status;

    function automatic logic [OFF_W-1:0] f_clamp(input logic signed [17:0] v,
                                                 input logic [OFF_W-1:0] span);
        logic signed [17:0] span_s;
        span_s = $signed({5'b0, span});
        if (v < 18'sd0) begin
            return '0;
        end else if (v > span_s) begin
            return span;
        end else begin
            return v[OFF_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/fuzzy_distance_to_speed.sv =====
// Fuzzy distance-to-speed controller, top level.
// Joins the sequencer (fdts_ctrl) and the datapath (fdts_dp). Depends on fdts_pkg.
//
// Input channel: i_valid / o_ready with i_distance (signed, 4 fraction bits).
// Output channel: o_valid / i_ready with o_speed (unsigned, 8 fraction bits).
// A transaction moves on either channel when its valid and ready are both high.
//
// One item is worked on at a time. After a distance is taken the block forms
// the three distance grades by reciprocal multiplication, sweeps SAMPLE_POINTS
// speed samples at one per cycle through the multiply-accumulate pipe, drains
// that pipe, runs the centroid division on the 17-step divider and loads the
// output register; o_valid and o_ready both rise as that register is loaded.
// The result waits in an output register: the next distance is accepted and
// worked on while it is not yet taken; a second result holds, with o_ready
// low, until i_ready frees that register.
// Reset (i_rst_n low at a clock edge) returns the sequencer to idle and drops
// any pending result.
module fuzzy_distance_to_speed #(
    parameter int SAMPLE_POINTS = 1000
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [fdts_pkg::DIST_W-1:0]  i_distance,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [fdts_pkg::SPEED_W-1:0] o_speed
);
    import fdts_pkg::*;

    t_cmd    cmd;
    t_status st;

    fdts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_ready (i_ready),
        .i_st        (st),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    fdts_dp #(
        .SAMPLE_POINTS (SAMPLE_POINTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_distance (i_distance),
        .i_cmd      (cmd),
        .o_st       (st),
        .o_speed    (o_speed)
    );

endmodule

// ===== rtl/fdts_div.sv =====
// Restoring divider, one quotient bit per cycle, QUO_W iterations.
// Requires num < den * 2**QUO_W. Depends on fdts_pkg.
module fdts_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [NUM_W-1:0]           i_num,
    input  logic [DEN_W-1:0]           i_den,
    output logic                       o_done,
    output logic [fdts_pkg::QUO_W-1:0] o_quo
);
    import fdts_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_den;
    logic [QUO_W-1:0] r_sh;
    logic [NUM_W:0]   cat;
    logic [NUM_W:0]   trial;

    assign cat   = {r_rem, r_sh[QUO_W-1]};
    assign trial = cat - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(QUO_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= NUM_W'(i_num[NUM_W-1:QUO_W]);
            r_sh  <= i_num[QUO_W-1:0];
            r_den <= NUM_W'(i_den);
        end else if (r_cnt != '0) begin
            // keep the partial remainder when the trial subtract goes negative
            r_rem <= trial[NUM_W] ? cat[NUM_W-1:0] : trial[NUM_W-1:0];
            r_sh  <= {r_sh[QUO_W-2:0], ~trial[NUM_W]};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_sh;

endmodule

// ===== rtl/fdts_ctrl.sv =====
// Sequencer: grade load, the sample sweep, the centroid division.
// Drives datapath commands and the output valid flag. Depends on fdts_pkg.
module fdts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  fdts_pkg::t_status i_st,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output fdts_pkg::t_cmd    o_cmd
);
    import fdts_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GRADE  = 3'd1;
    localparam logic [2:0] ST_SWEEP  = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_DSTART = 3'd4;
    localparam logic [2:0] ST_DWAIT  = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_oval, n_oval;

    always_comb begin
        n_state = r_state;
        n_oval  = r_oval;
        o_cmd   = '0;
        if (r_oval && i_out_ready) begin
            n_oval = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_GRADE;
                end
            end
            ST_GRADE: begin
                o_cmd.grade_wr = 1'b1;
                n_state        = ST_SWEEP;
            end
            ST_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_st.sweep_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the multiply-accumulate pipe to empty
                if (!i_st.pipe_busy) begin
                    n_state = ST_DSTART;
                end
            end
            ST_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (i_st.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold the result until the output register is free
                if (!r_oval || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_oval         = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_oval;

endmodule

// ===== rtl/fdts_dp.sv =====
// Datapath: distance grades by reciprocal multiplication, incremental speed-set
// sweep, multiply-accumulate pipe and output register. Depends on fdts_pkg, fdts_div.
module fdts_dp #(
    parameter int SAMPLE_POINTS = 1000
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [fdts_pkg::DIST_W-1:0]  i_distance,
    input  fdts_pkg::t_cmd               i_cmd,
    output fdts_pkg::t_status            o_st,
    output logic [fdts_pkg::SPEED_W-1:0] o_speed
);
    import fdts_pkg::*;

    localparam int I_W   = $clog2(SAMPLE_POINTS);
    localparam int S_W   = I_W + GRADE_W;
    localparam int W_W   = 2 * I_W + GRADE_W;
    localparam int P_W   = I_W + GRADE_W;
    localparam int NUM_W = W_W + 12;
    localparam int DEN_W = S_W + 6;
    localparam int QC_W  = $clog2(SAMPLE_POINTS * 197);
    localparam int Q_W   = (QC_W > 18) ? QC_W : 18;

    localparam logic [Q_W-1:0] Q_U20  = Q_W'(32768);
    localparam logic [Q_W-1:0] Q_U60  = Q_W'(98304);
    localparam logic [Q_W-1:0] Q_U100 = Q_W'(163840);
    localparam logic [Q_W-1:0] Q_STEP = Q_W'(196);

    function automatic logic [GRADE_W-1:0] f_min(input logic [GRADE_W-1:0] a,
                                                 input logic [GRADE_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [GRADE_W-1:0] f_max(input logic [GRADE_W-1:0] a,
                                                 input logic [GRADE_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    logic [DIST_W-1:0]  r_dist;
    logic [GRADE_W-1:0] r_gs, r_gm, r_gl;
    logic [I_W-1:0]     r_idx;
    logic [Q_W-1:0]     r_qa;
    logic [9:0]         r_ra;
    logic               r_v1, r_v2;
    logic [GRADE_W-1:0] r_a1;
    logic [I_W-1:0]     r_i1;
    logic [P_W-1:0]     r_prod;
    logic [S_W-1:0]     r_s;
    logic [W_W-1:0]     r_w;
    logic [SPEED_W-1:0] r_speed;

    logic signed [17:0] d_ext;
    logic [OFF_W-1:0]   off_s, off_m, off_l;
    logic [GP_W-1:0]    prod_s, prod_m, prod_l;
    logic [NUM_W-1:0]   div_num, w_ext, s_ext;
    logic [DEN_W-1:0]   div_den, s_d;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    logic [10:0]        ra_sum;
    logic               rnz;
    logic [GRADE_W-1:0] ss, sm, sl, a_comb;

    // clamped ramp offsets; the clamps give exact 0 and 1.0 at the flat ends
    always_comb begin
        d_ext  = {{2{r_dist[DIST_W-1]}}, r_dist};
        off_s  = f_clamp(D450 - d_ext, SPAN_SMALL);
        off_m  = (d_ext <= D500) ? f_clamp(d_ext - D250, SPAN_MID)
                                 : f_clamp(D750 - d_ext, SPAN_MID);
        off_l  = f_clamp(d_ext - D500, SPAN_LARGE);
        prod_s = GP_W'(off_s) * GP_W'(RCP_SMALL);
        prod_m = GP_W'(off_m) * GP_W'(RCP_MID);
        prod_l = GP_W'(off_l) * GP_W'(RCP_LARGE);
    end

    always_comb begin
        w_ext   = NUM_W'(r_w);
        s_ext   = NUM_W'(r_s);
        s_d     = DEN_W'(r_s);
        // (1536*W + 25*S) / (50*S)
        div_num = (w_ext << 10) + (w_ext << 9) + (s_ext << 4) + (s_ext << 3) + s_ext;
        div_den = (s_d << 5) + (s_d << 4) + (s_d << 1);
    end

    fdts_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // r_qa/r_ra hold floor and remainder of 3*i*65536/1000, so every speed
    // ramp is r_qa minus a constant, or a constant minus its ceiling
    always_comb begin
        ra_sum = {1'b0, r_ra} + STEP_R;
        rnz    = (r_ra != 10'd0);
        if (r_qa <= Q_U20) begin
            ss = GRADE_ONE;
        end else if (r_qa > Q_U60) begin
            ss = '0;
        end else begin
            ss = GRADE_W'(Q_U60 - r_qa - Q_W'(rnz));
        end
        if ((r_qa <= Q_U20) || (r_qa > Q_U100)) begin
            sm = '0;
        end else if (r_qa <= Q_U60) begin
            sm = GRADE_W'(r_qa - Q_U20);
        end else begin
            sm = GRADE_W'(Q_U100 - r_qa - Q_W'(rnz));
        end
        if (r_qa <= Q_U60) begin
            sl = '0;
        end else if (r_qa > Q_U100) begin
            sl = GRADE_ONE;
        end else begin
            sl = GRADE_W'(r_qa - Q_U60);
        end
        a_comb = f_max(f_max(f_min(r_gs, ss), f_min(r_gm, sm)), f_min(r_gl, sl));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.sweep_step;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dist <= i_distance;
            r_idx  <= '0;
            r_qa   <= '0;
            r_ra   <= '0;
            r_s    <= '0;
            r_w    <= '0;
        end else begin
            if (i_cmd.sweep_step) begin
                r_idx <= r_idx + 1'b1;
                if (ra_sum >= R_MOD) begin
                    r_ra <= 10'(ra_sum - R_MOD);
                    r_qa <= r_qa + Q_STEP + 1'b1;
                end else begin
                    r_ra <= ra_sum[9:0];
                    r_qa <= r_qa + Q_STEP;
                end
            end
            if (r_v1) begin
                r_s <= r_s + S_W'(r_a1);
            end
            if (r_v2) begin
                r_w <= r_w + W_W'(r_prod);
            end
        end
        r_a1   <= a_comb;
        r_i1   <= r_idx;
        r_prod <= P_W'(r_i1) * P_W'(r_a1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grade_wr) begin
            r_gs <= prod_s[SH_SMALL +: GRADE_W];
            r_gm <= prod_m[SH_MID +: GRADE_W];
            r_gl <= prod_l[SH_LARGE +: GRADE_W];
        end
        if (i_cmd.load_out) begin
            if (r_s == '0) begin
                r_speed <= '0;
            end else if (div_quo > QUO_W'(SPEED_MAX)) begin
                r_speed <= SPEED_MAX;
            end else begin
                r_speed <= div_quo[SPEED_W-1:0];
            end
        end
    end

    assign o_st.div_done   = div_done;
    assign o_st.sweep_last = (r_idx == I_W'(SAMPLE_POINTS - 1));
    assign o_st.pipe_busy  = r_v1 | r_v2;
    assign o_speed         = r_speed;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for fuzzy_distance_to_speed.
// A scoreboard class predicts each centroid speed and checks it in order.
// Depends on fdts_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb;

    import fdts_pkg::*;

    localparam int SAMPLE_POINTS = 1000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1200;
    localparam int HOLD_CYCLES = 3000;
    localparam int PHASE_ITEMS = 138;
    localparam int PRESSURE_ITEMS = 4;

    // distance breakpoints not in the package, and speed breakpoints in 0.04 units
    localparam int D1000 = 16000;
    localparam int U20 = 500;
    localparam int U60 = 1500;
    localparam int U100 = 2500;
    localparam longint GRADE_FULL = 65536;

    class speed_scoreboard;
        logic [SPEED_W-1:0] expected_speeds[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function longint ramp(input int off, input int span);
            return (longint'(off) * GRADE_FULL) / span;
        endfunction

        static function longint min2(input longint a, input longint b);
            return (a < b) ? a : b;
        endfunction

        function logic [SPEED_W-1:0] predict_speed(input logic signed [DIST_W-1:0] dist_val);
            int dv;
            int u;
            longint gs, gm, gl;
            longint ss, sm, sl;
            longint a, s, w, q;
            dv = int'(dist_val);
            if (dv <= 0) gs = GRADE_FULL;
            else if (dv > int'(D450)) gs = 0;
            else gs = ramp(int'(D450) - dv, int'(D450));
            if (dv <= int'(D250) || dv > int'(D750)) gm = 0;
            else if (dv <= int'(D500)) gm = ramp(dv - int'(D250), int'(D500) - int'(D250));
            else gm = ramp(int'(D750) - dv, int'(D750) - int'(D500));
            if (dv <= int'(D500)) gl = 0;
            else if (dv > D1000) gl = GRADE_FULL;
            else gl = ramp(dv - int'(D500), D1000 - int'(D500));
            s = 0;
            w = 0;
            for (int i = 0; i < SAMPLE_POINTS; i++) begin
                u = 3 * i;
                if (u <= U20) ss = GRADE_FULL;
                else if (u > U60) ss = 0;
                else ss = ramp(U60 - u, U60 - U20);
                if (u <= U20 || u > U100) sm = 0;
                else if (u <= U60) sm = ramp(u - U20, U60 - U20);
                else sm = ramp(U100 - u, U100 - U60);
                if (u <= U60) sl = 0;
                else if (u > U100) sl = GRADE_FULL;
                else sl = ramp(u - U60, U100 - U60);
                // combine the clipped sets by max, not by sum
                a = min2(gs, ss);
                if (min2(gm, sm) > a) a = min2(gm, sm);
                if (min2(gl, sl) > a) a = min2(gl, sl);
                s += a;
                w += longint'(i) * a;
            end
            if (s == 0) begin
                q = 0;
            end else begin
                q = (1536 * w + 25 * s) / (50 * s);
                if (q > longint'(SPEED_MAX)) q = longint'(SPEED_MAX);
            end
            return q[SPEED_W-1:0];
        endfunction

        function void note_distance(input logic [DIST_W-1:0] dist_val);
            expected_speeds.push_back(predict_speed(dist_val));
        endfunction

        function void check_speed(input logic [SPEED_W-1:0] got);
            logic [SPEED_W-1:0] want;
            if (expected_speeds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("speed error: got %0d with no distance outstanding", got);
            end else begin
                want = expected_speeds.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("speed error: expected %0d, got %0d", want, got);
                end
            end
        endfunction

        function int pending();
            return expected_speeds.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [DIST_W-1:0]  i_distance;
    logic               o_valid;
    logic               i_ready;
    logic [SPEED_W-1:0] o_speed;

    speed_scoreboard sb = new();

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req = 0;

    int directed_distances [23] = '{
        -32768, -1, 0, 1, 2000, 3999, 4000, 4001, 6000, 7200, 7201, 7999,
        8000, 8001, 10000, 11999, 12000, 12001, 14000, 15999, 16000, 16001, 32767
    };
    int breakpoints [6] = '{0, 4000, 7200, 8000, 12000, 16000};

    fuzzy_distance_to_speed #(
        .SAMPLE_POINTS(SAMPLE_POINTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_distance (i_distance),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_speed    (o_speed)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hold valid and payload until the transaction is taken.
    task automatic send_distance(input logic [DIST_W-1:0] dist_val);
        int gap;
        gap = 0;
        if (tx_idle_pct > 0 && $urandom_range(0, 7) == 0) begin
            // long gap so the next start lands at any point of the sweep
            gap = $urandom_range(1, 1100);
        end else begin
            while ($urandom_range(0, 99) < tx_idle_pct) gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_distance <= dist_val;
        do @(posedge i_clk); while (!o_ready);
        sb.note_distance(dist_val);
    endtask

    function automatic logic [DIST_W-1:0] random_distance();
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            v = $urandom;
        end else if (pick == 2) begin
            v = breakpoints[$urandom_range(0, 5)] + $urandom_range(0, 16) - 8;
        end else begin
            v = $urandom_range(0, 16200) - 100;
        end
        return v[DIST_W-1:0];
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        tx_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
        repeat (count) send_distance(random_distance());
    endtask

    // Receiver: check each accepted speed, stall at random or hold off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) sb.check_speed(o_speed);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (rx_hold_req) begin
                rx_hold_req = 0;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Watchdog: abort when no transaction moves for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_distance <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        foreach (directed_distances[k]) send_distance(directed_distances[k][DIST_W-1:0]);

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(53, 0, PHASE_ITEMS);

        // Fill the block behind a long receiver hold-off.
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_req = 1;
        repeat (PRESSURE_ITEMS) send_distance(random_distance());

        run_phase(0, 53, PHASE_ITEMS);
        run_phase(21, 21, PHASE_ITEMS);

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fdts_pkg.sv
rtl/fdts_div.sv
rtl/fdts_ctrl.sv
rtl/fdts_dp.sv
rtl/fuzzy_distance_to_speed.sv
tb/tb.sv
